### sv/lfp_pkg.sv
// Package for the line follower PID block: payload types, codes, constants.
package lfp_pkg;

  // Width of the saturating integral accumulator.
  localparam int INTEGRAL_WIDTH = 40;
  // Number of edge changes allowed before the rule stops firing.
  localparam logic [1:0] MAX_CHANGES = 2'd2;
  // Brightness at or below this level counts as dark.
  localparam logic [6:0] DARK_LEVEL = 7'd10;
  // Timer thresholds in microseconds.
  localparam logic [31:0] START_DELAY_US = 32'd6000000;
  localparam logic [31:0] CHANGE_TIME_US = 32'd1000000;
  // Fraction bits of the turn sum, and the shift of the P and D terms into it.
  localparam int TURN_FRAC = 24;
  localparam int PD_SHIFT = 16;
  // Width of the turn sum register.
  localparam int SUM_W = 48;
  // Magnitude of the turn used when the integral term saturates.
  localparam int TURN_SAT = 40000;
  // Integral term magnitude at which the turn saturates (as a bit position).
  localparam int ITERM_LIMIT_BIT = 42;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_TARGET_LEVEL = 3'd3,
    CFG_BIAS_OFFSET  = 3'd4,
    CFG_PERIOD_SCALE = 3'd5,
    CFG_DRIVE_POWER  = 3'd6
  } lfp_cfg_index_t;

  // One input beat.
  typedef struct packed {
    logic [6:0]  brightness;
    logic [15:0] elapsed_us;
  } lfp_in_t;

  // One result beat.
  typedef struct packed {
    logic signed [15:0] turn_value;
    logic signed [7:0]  power;
    logic               edge_side;
    logic               changing;
  } lfp_out_t;

  // Controller states, one per datapath step.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIMER,
    ST_INTEG,
    ST_DTERM,
    ST_ITERM,
    ST_SUM,
    ST_FINISH
  } lfp_state_t;

  // Step enables from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic timer;
    logic integ;
    logic dterm;
    logic iterm;
    logic sum;
    logic finish;
  } lfp_cmd_t;

endpackage

### sv/lfp_ctrl.sv
// Controller state machine that sequences the PID steps and owns the handshakes.
module lfp_ctrl import lfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_stall,
  output logic     result_valid,
  input  logic     result_stall,
  output lfp_cmd_t cmd
);

  lfp_state_t state;
  lfp_state_t state_next;
  logic       out_free;

  // The output register can take a new beat when empty or being emptied now.
  assign out_free = !result_valid || !result_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (sample_valid) state_next = ST_TIMER;
      ST_TIMER:  state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_DTERM;
      ST_DTERM:  state_next = ST_ITERM;
      ST_ITERM:  state_next = ST_SUM;
      ST_SUM:    state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Step commands and input stall.
  always_comb begin
    cmd = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.load = sample_valid;
      end
      ST_TIMER:  cmd.timer = 1'b1;
      ST_INTEG:  cmd.integ = 1'b1;
      ST_DTERM:  cmd.dterm = 1'b1;
      ST_ITERM:  cmd.iterm = 1'b1;
      ST_SUM:    cmd.sum = 1'b1;
      ST_FINISH: cmd.finish = out_free;
      default:   cmd = '0;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set when a result is written, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // A written result is offered in the next cycle.
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_valid)
    else $error("result not valid after finish");

  // An accepted beat starts the timer step.
  a_accept_step: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> (state == ST_TIMER))
    else $error("accepted beat did not start processing");

  // At most one datapath step runs in a cycle.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.timer, cmd.integ, cmd.dterm, cmd.iterm, cmd.sum, cmd.finish}))
    else $error("more than one step enabled");

  // A full, stalled output holds the block in its last step.
  a_hold_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && result_valid && result_stall) |=> (state == ST_FINISH))
    else $error("finish step left while output was blocked");
`endif

endmodule

### sv/lfp_datapath.sv
// Datapath: configuration registers, controller state, PID arithmetic, result register.
module lfp_datapath import lfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lfp_cmd_t    cmd,
  input  lfp_in_t     sample,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output lfp_out_t    result
);

  localparam int IW = INTEGRAL_WIDTH;
  // Accumulator width holding the integral plus one 25-bit increment.
  localparam int IACC_W = ((IW > 25) ? IW : 25) + 1;
  // Integral term product width, never narrower than the turn sum.
  localparam int IP_W = ((IW + 16) > SUM_W) ? (IW + 16) : SUM_W;
  localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [IACC_W-1:0] IMAX_EXT = IACC_W'(IMAX);
  localparam logic signed [IACC_W-1:0] IMIN_EXT = IACC_W'(IMIN);
  localparam logic signed [IP_W-1:0] ILIM = IP_W'(1) << ITERM_LIMIT_BIT;
  localparam logic signed [SUM_W-1:0] ROUND_ADD = (SUM_W'(1) << TURN_FRAC) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_POS = SUM_W'(TURN_SAT);

  // Configuration registers.
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic [6:0]         target_level;
  logic signed [15:0] bias_offset;
  logic [15:0]        period_scale;
  logic signed [7:0]  drive_power;

  // Controller state carried across beats.
  logic signed [IW-1:0] integral_sum;
  logic signed [8:0]    previous_error;
  logic [31:0]          elapsed_timer;
  logic                 traced_edge;
  logic                 change_active;
  logic [1:0]           changes_done;

  // Working registers of one beat.
  lfp_in_t              sample_reg;
  logic signed [7:0]    diff;
  logic signed [9:0]    ddt;
  logic signed [24:0]   d_prod;
  logic signed [23:0]   p_term;
  logic signed [25:0]   d_term;
  logic signed [IP_W-1:0] i_term;
  logic signed [SUM_W-1:0] total;
  logic                 i_sat;
  logic                 i_neg;

  // Combinational values.
  logic [32:0]          timer_sum;
  logic [31:0]          timer_sat;
  logic                 dark;
  logic signed [7:0]    diff_c;
  logic signed [9:0]    ddt_c;
  logic signed [24:0]   d_prod_c;
  logic [31:0]          elapsed_timer_next;
  logic                 traced_edge_next;
  logic                 change_active_next;
  logic [1:0]           changes_done_next;
  logic signed [IACC_W-1:0] iacc;
  logic signed [IW-1:0] integral_sum_next;
  logic signed [IP_W-1:0] i_term_c;
  logic signed [SUM_W-1:0] pd_sum;
  logic signed [SUM_W-1:0] total_c;
  logic signed [SUM_W-1:0] rounded;
  logic signed [SUM_W-1:0] quotient;
  logic signed [SUM_W-1:0] turn_pre;
  logic signed [SUM_W-1:0] turn_signed;
  logic signed [15:0]      turn_c;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      target_level <= '0;
      bias_offset  <= '0;
      period_scale <= '0;
      drive_power  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GAIN_P:       gain_p       <= cfg_data;
        CFG_GAIN_I:       gain_i       <= cfg_data;
        CFG_GAIN_D:       gain_d       <= cfg_data;
        CFG_TARGET_LEVEL: target_level <= cfg_data[6:0];
        CFG_BIAS_OFFSET:  bias_offset  <= cfg_data;
        CFG_PERIOD_SCALE: period_scale <= cfg_data;
        CFG_DRIVE_POWER:  drive_power  <= cfg_data[7:0];
        default:          gain_p       <= gain_p;
      endcase
    end
  end

  // Timer step: saturating timer, line-change rule, error and its product.
  always_comb begin
    timer_sum = {1'b0, elapsed_timer} + {17'd0, sample_reg.elapsed_us};
    timer_sat = timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];
    dark = sample_reg.brightness <= DARK_LEVEL;
    diff_c = $signed({1'b0, sample_reg.brightness}) - $signed({1'b0, target_level});
    ddt_c = 10'(diff_c) - 10'(previous_error);
    d_prod_c = diff_c * $signed({1'b0, period_scale});

    elapsed_timer_next = timer_sat;
    traced_edge_next = traced_edge;
    change_active_next = change_active;
    changes_done_next = changes_done;
    if (change_active) begin
      if (timer_sat >= CHANGE_TIME_US) begin
        elapsed_timer_next = '0;
        traced_edge_next = !traced_edge;
        change_active_next = 1'b0;
        if (changes_done != 2'd3) begin
          changes_done_next = changes_done + 2'd1;
        end
      end
    end else if (dark && (changes_done < MAX_CHANGES) && (timer_sat >= START_DELAY_US)) begin
      elapsed_timer_next = '0;
      change_active_next = 1'b1;
    end
  end

  // Integral step: saturating accumulate of the error times the period.
  always_comb begin
    iacc = IACC_W'(integral_sum) + IACC_W'(d_prod);
    if (iacc > IMAX_EXT) begin
      integral_sum_next = IMAX;
    end else if (iacc < IMIN_EXT) begin
      integral_sum_next = IMIN;
    end else begin
      integral_sum_next = iacc[IW-1:0];
    end
  end

  // Integral term product and the Q.24 sum of all terms.
  always_comb begin
    i_term_c = gain_i * integral_sum;
    pd_sum = SUM_W'(p_term) + SUM_W'(d_term);
    total_c = (pd_sum <<< PD_SHIFT) + (SUM_W'(bias_offset) <<< TURN_FRAC)
            + $signed(i_term[SUM_W-1:0]);
  end

  // Final step: truncate toward zero, negate on edge 0, saturate to 16 bits.
  always_comb begin
    rounded = total + (total[SUM_W-1] ? ROUND_ADD : '0);
    quotient = rounded >>> TURN_FRAC;
    if (i_sat) begin
      turn_pre = i_neg ? -SAT_POS : SAT_POS;
    end else begin
      turn_pre = quotient;
    end
    turn_signed = traced_edge ? turn_pre : -turn_pre;
    if (turn_signed > SUM_W'(32767)) begin
      turn_c = 16'sh7FFF;
    end else if (turn_signed < -SUM_W'(32768)) begin
      turn_c = 16'sh8000;
    end else begin
      turn_c = turn_signed[15:0];
    end
  end

  // State carried across beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
      elapsed_timer  <= '0;
      traced_edge    <= 1'b0;
      change_active  <= 1'b0;
      changes_done   <= '0;
    end else begin
      if (cmd.timer) begin
        previous_error <= {diff_c[7], diff_c};
        elapsed_timer  <= elapsed_timer_next;
        traced_edge    <= traced_edge_next;
        change_active  <= change_active_next;
        changes_done   <= changes_done_next;
      end
      if (cmd.integ) begin
        integral_sum <= integral_sum_next;
      end
    end
  end

  // Per-beat working registers, one group per step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= sample;
    end
    if (cmd.timer) begin
      diff   <= diff_c;
      ddt    <= ddt_c;
      d_prod <= d_prod_c;
    end
    if (cmd.integ) begin
      p_term <= gain_p * diff;
    end
    if (cmd.dterm) begin
      d_term <= gain_d * ddt;
    end
    if (cmd.iterm) begin
      i_term <= i_term_c;
    end
    if (cmd.sum) begin
      total <= total_c;
      i_sat <= (i_term >= ILIM) || (i_term <= -ILIM);
      i_neg <= i_term[IP_W-1];
    end
    if (cmd.finish) begin
      result.turn_value <= turn_c;
      result.power      <= drive_power;
      result.edge_side  <= traced_edge;
      result.changing   <= change_active;
    end
  end

endmodule

### sv/line_follow_pid_with_side_switch_top.sv
// A sample beat is accepted only in the idle state; it then passes the controller's steps
// in order (timer, integral, D term, I term, sum, finish), and a new sample is accepted
// only once the finish step has written its result and the block is back in idle.
// A blocked output holds the block in its finish step until the result is taken.
// Reset (synchronous, active high) clears the configuration registers, the integral, timer,
// error history and edge state; the first edge traced is edge 0.
module line_follow_pid_with_side_switch_top import lfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  lfp_in_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output lfp_out_t    result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lfp_cmd_t cmd;

  // Step sequencer and handshakes.
  lfp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // Arithmetic, state and result register.
  lfp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample    (sample),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

### sim/line_follow_pid_with_side_switch_top_tb.sv
// Self-checking testbench for the line follower PID steering block with edge switching.
`timescale 1ns / 100ps

module line_follow_pid_with_side_switch_top_tb;
  import lfp_pkg::*;

  // Index past the end of the register list; a write there must change nothing.
  localparam logic [2:0] CFG_NO_REGISTER = 3'd7;
  // Mismatch reports beyond this count are only counted.
  localparam int REPORT_LIMIT = 30;
  // Random part: phases of beats, each under its own register setting.
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BEATS = 95;
  // Run of bright beats at the longest gap, long enough for the timer to pass six seconds.
  localparam int SOAK_BEATS = 120;
  localparam int TAIL_CYCLES = 12;

  // Fixed-point scales and limits of the steering datapath.
  localparam longint AREA_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint AREA_MIN = -AREA_MAX - 1;
  localparam longint PD_SCALE = longint'(1) <<< PD_SHIFT;
  localparam longint TURN_SCALE = longint'(1) <<< TURN_FRAC;
  localparam longint ITERM_MAX = longint'(1) <<< ITERM_LIMIT_BIT;
  localparam longint TIMER_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam longint TURN_HI = 32767;
  localparam longint TURN_LO = -32768;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  lfp_in_t     sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  lfp_out_t    result;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  line_follow_pid_with_side_switch_top DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file.
  logic signed [15:0] kp_reg = '0;
  logic signed [15:0] ki_reg = '0;
  logic signed [15:0] kd_reg = '0;
  logic [6:0]         target_reg = '0;
  logic signed [15:0] bias_reg = '0;
  logic [15:0]        period_reg = '0;
  logic signed [7:0]  power_reg = '0;

  // Shadow controller state.
  longint     err_area;
  longint     last_diff;
  longint     us_clock;
  logic       trace_side;
  logic       side_swap;
  logic [1:0] swap_count;

  lfp_in_t  sample_backlog[$];
  lfp_out_t steer_due[$];
  lfp_out_t want;
  logic     sample_taken = 1'b0;
  int       idle_pct = 8;

  int unsigned items_queued = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned settings_loaded = 0;
  int unsigned flips_seen = 0;
  int unsigned timer_clamps = 0;
  int unsigned area_clamps = 0;
  int unsigned iterm_clamps = 0;

  // Works out the result of one sample beat and advances the shadow state.
  function automatic lfp_out_t steer_step(input lfp_in_t s);
    longint   kp, ki, kd, bias, diff, area_step, ddt, pd_sum, mag, kmag, prod, turn;
    logic     against;
    lfp_out_t r;
    kp = kp_reg;
    ki = ki_reg;
    kd = kd_reg;
    bias = bias_reg;
    // The microsecond timer holds at its top value instead of wrapping.
    us_clock = us_clock + longint'(s.elapsed_us);
    if (us_clock > TIMER_MAX) begin
      us_clock = TIMER_MAX;
      timer_clamps++;
    end
    // A running change ends after one second; a dark beat after six seconds starts one.
    if (side_swap) begin
      if (us_clock >= longint'(CHANGE_TIME_US)) begin
        us_clock = 0;
        trace_side = ~trace_side;
        side_swap = 1'b0;
        if (swap_count != '1) swap_count = swap_count + 2'd1;
        flips_seen++;
      end
    end else if (s.brightness <= DARK_LEVEL && swap_count < MAX_CHANGES &&
                 us_clock >= longint'(START_DELAY_US)) begin
      us_clock = 0;
      side_swap = 1'b1;
    end
    // Integral of the error times the control period, clamped at its width.
    diff = longint'(s.brightness) - longint'(target_reg);
    area_step = diff * longint'(period_reg);
    if (area_step > 0 && err_area > AREA_MAX - area_step) begin
      err_area = AREA_MAX;
      area_clamps++;
    end else if (area_step < 0 && err_area < AREA_MIN - area_step) begin
      err_area = AREA_MIN;
      area_clamps++;
    end else begin
      err_area = err_area + area_step;
    end
    ddt = diff - last_diff;
    last_diff = diff;
    // P, D and bias terms aligned to 24 fraction bits.
    pd_sum = (kp * diff + kd * ddt) * PD_SCALE + bias * TURN_SCALE;
    // The I term is formed from magnitudes; past its limit the turn takes a fixed size.
    mag = (err_area < 0) ? -err_area : err_area;
    kmag = (ki < 0) ? -ki : ki;
    prod = mag * kmag;
    against = (err_area < 0) != (ki < 0);
    if (prod >= ITERM_MAX) begin
      turn = against ? -TURN_SAT : TURN_SAT;
      iterm_clamps++;
    end else begin
      turn = (pd_sum + (against ? -prod : prod)) / TURN_SCALE;
    end
    // Steering flips sign on edge 0, then saturates to 16 bits.
    if (!trace_side) turn = -turn;
    if (turn > TURN_HI) turn = TURN_HI;
    else if (turn < TURN_LO) turn = TURN_LO;
    r.turn_value = turn[15:0];
    r.power = power_reg;
    r.edge_side = trace_side;
    r.changing = side_swap;
    return r;
  endfunction

  task automatic field_error(input string field, input longint exp_v, input longint got_v);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
  endtask

  // Sample driver: a new beat goes out at the falling edge once the last one was taken.
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_taken) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        sample <= sample_backlog.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Checker: predicts each accepted sample beat and compares each result beat in order.
  always @(posedge clk) begin
    if (rst) begin
      sample_taken <= 1'b0;
      err_area = 0;
      last_diff = 0;
      us_clock = 0;
      trace_side = 1'b0;
      side_swap = 1'b0;
      swap_count = '0;
    end else begin
      sample_taken <= sample_valid && !sample_stall;
      if (result_valid && !result_stall) begin
        if (steer_due.size() == 0) begin
          mismatches++;
          $error("Result beat with no sample outstanding: turn_value %0d", result.turn_value);
        end else begin
          want = steer_due.pop_front();
          if (result.turn_value !== want.turn_value)
            field_error("turn_value", want.turn_value, result.turn_value);
          if (result.power !== want.power)
            field_error("power", want.power, result.power);
          if (result.edge_side !== want.edge_side)
            field_error("edge_side", want.edge_side, result.edge_side);
          if (result.changing !== want.changing)
            field_error("changing", want.changing, result.changing);
          results_checked++;
        end
      end
      if (sample_valid && !sample_stall) steer_due.push_back(steer_step(sample));
    end
  end

  task automatic add_sample(input logic [6:0] level, input logic [15:0] gap_us);
    lfp_in_t s;
    s.brightness = level;
    s.elapsed_us = gap_us;
    sample_backlog.push_back(s);
    items_queued++;
  endtask

  // Sender holds off until every result owed so far has been checked.
  task automatic wait_drained();
    while (results_checked != items_queued) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_GAIN_P:       kp_reg = data;
      CFG_GAIN_I:       ki_reg = data;
      CFG_GAIN_D:       kd_reg = data;
      CFG_TARGET_LEVEL: target_reg = data[6:0];
      CFG_BIAS_OFFSET:  bias_reg = data;
      CFG_PERIOD_SCALE: period_reg = data;
      CFG_DRIVE_POWER:  power_reg = data[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] kp, ki, kd, tgt, bias, per, pwr);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_TARGET_LEVEL, tgt);
    write_reg(CFG_BIAS_OFFSET, bias);
    write_reg(CFG_PERIOD_SCALE, per);
    write_reg(CFG_DRIVE_POWER, pwr);
    settings_loaded++;
  endtask

  // Half of the gains span the full range, the rest stay small enough to steer unclamped.
  function automatic logic [15:0] pick_gain();
    int v;
    if ($urandom_range(1) != 0) v = $urandom;
    else v = int'($urandom_range(1023)) - 512;
    return v[15:0];
  endfunction

  // Stimulus sequence.
  initial begin
    logic [6:0]  ramp_level [20];
    logic [15:0] toggle_us [4];
    logic        keep_last_change;
    logic [6:0]  level;
    logic [15:0] gap_us;
    int          pick;
    int          ki_small;
    ramp_level = '{7'd0, 7'd127, 7'd0, 7'd100, 7'd0, 7'd11, 7'd0, 7'd10, 7'd0, 7'd64,
                   7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
    toggle_us = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers still at reset: both input extremes must give a zero turn.
    add_sample(7'd0, 16'h0000);
    add_sample(7'd127, 16'hFFFF);
    wait_drained();

    // Extreme gains with the target and power at their top values. The error stays at its
    // negative limit long enough for the integral term to pass its limit at the end.
    // Dark beats here come before six seconds, so no change may start.
    load_settings(16'h7FFF, 16'h8000, 16'h8000, 16'h007F, 16'h7FFF, 16'hFFFF, 16'h007F);
    for (int i = 0; i < 20; i++) add_sample(ramp_level[i], toggle_us[i % 4]);
    wait_drained();

    // A write past the register list must leave every setting as it was.
    write_reg(CFG_NO_REGISTER, 16'hFFFF);
    add_sample(7'd127, 16'h1234);
    wait_drained();

    // Opposite extremes, with junk above the narrow registers' widths. Zero period
    // freezes the integral, whose term now saturates with the other sign.
    load_settings(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFF80, 16'h8000, 16'h0000, 16'hFF80);
    add_sample(7'd127, 16'h00FF);
    add_sample(7'd0, 16'hFF00);
    add_sample(7'd55, 16'h0F0F);
    wait_drained();

    // Random phases. Once the first change has begun, dark beats are left out so that
    // the last allowed change stays for the run below.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_pct = (ph == 4) ? 0 : 8;
      load_settings(pick_gain(), pick_gain(), pick_gain(), 16'($urandom), pick_gain(),
                    16'($urandom), 16'($urandom));
      keep_last_change = (swap_count != '0) || side_swap;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (keep_last_change) level = 7'($urandom_range(127, int'(DARK_LEVEL) + 1));
        else if ($urandom_range(3) == 0) level = 7'($urandom_range(int'(DARK_LEVEL)));
        else level = 7'($urandom_range(127));
        pick = $urandom_range(9);
        if (pick == 0) gap_us = 16'h0000;
        else if (pick == 1) gap_us = 16'hFFFF;
        else gap_us = 16'($urandom);
        add_sample(level, gap_us);
      end
      wait_drained();
    end

    // Run with no idling: bright beats at the longest gap carry the timer past six
    // seconds. A dark beat then starts a change while the count allows one, bright
    // beats finish it, and the dark beats after that start one only if still allowed.
    idle_pct = 0;
    ki_small = $urandom_range(7, 1);
    if ($urandom_range(1) != 0) ki_small = -ki_small;
    load_settings(16'(int'($urandom_range(511)) - 256), ki_small[15:0],
                  16'(int'($urandom_range(511)) - 256), 16'h0000,
                  16'(int'($urandom_range(255)) - 128), 16'hFFFF, 16'($urandom));
    for (int n = 0; n < SOAK_BEATS; n++) add_sample(7'($urandom_range(127, 126)), 16'hFFFF);
    add_sample(7'd0, 16'hFFFF);
    for (int n = 0; n < 20; n++) add_sample(7'($urandom_range(127, 50)), 16'hFFFF);
    for (int n = 0; n < 3; n++) add_sample(7'($urandom_range(int'(DARK_LEVEL))), 16'hFFFF);
    wait_drained();

    // Let any stray result beat show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (steer_due.size() != 0) begin
      mismatches++;
      $error("%0d expected results never arrived", steer_due.size());
    end
    $display("Checked %0d results from %0d samples under %0d register settings; %0d edge flips.",
             results_checked, items_queued, settings_loaded, flips_seen);
    $display("Clamp hits: turn from integral term %0d, integral %0d, timer %0d.",
             iterm_clamps, area_clamps, timer_clamps);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #1_000_000;
    $display("Watchdog expired with %0d of %0d results checked", results_checked, items_queued);
    $display("TEST FAILED");
    $finish;
  end

endmodule
